// File: rtl/tdt_pkg.sv
// Types, constants and register reset values for the tap and double-tap detector.
`default_nettype none

package tdt_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned IdW     = 5;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StampW  = 63;
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned RadiusW = 35;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = RadiusW;

  typedef enum logic [1:0] {
    CMD_DOWN  = 2'd0,
    CMD_UP    = 2'd1,
    CMD_OTHER = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAP_TIMEOUT    = 2'd0,
    CFG_TAP_RADIUS_SQ  = 2'd1,
    CFG_DTAP_TIMEOUT   = 2'd2,
    CFG_DTAP_RADIUS_SQ = 2'd3
  } cfg_idx_e;

  localparam logic [TimeoutW-1:0] TapTimeoutRst    = 32'd100000000;
  localparam logic [RadiusW-1:0]  TapRadiusSqRst   = 35'd64;
  localparam logic [TimeoutW-1:0] DtapTimeoutRst   = 32'd300000000;
  localparam logic [RadiusW-1:0]  DtapRadiusSqRst  = 35'd10000;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [CountW-1:0]        pointer_count;
    logic [IdW-1:0]           pointer_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [StampW-1:0]        touch_stamp;
    logic [StampW-1:0]        press_time;
  } in_item_t;

  typedef struct packed {
    logic tap_seen;
    logic double_tap_seen;
  } out_item_t;

  typedef struct packed {
    logic [TimeoutW-1:0] tap_timeout;
    logic [RadiusW-1:0]  tap_radius_sq;
    logic [TimeoutW-1:0] double_tap_timeout;
    logic [RadiusW-1:0]  double_tap_radius_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] press_x;
    logic signed [CoordW-1:0] press_y;
    logic [IdW-1:0]           press_id;
    logic [StampW-1:0]        last_tap_stamp;
    logic signed [CoordW-1:0] last_tap_x;
    logic signed [CoordW-1:0] last_tap_y;
  } gesture_t;

endpackage

`default_nettype wire

// File: rtl/tdt_eval.sv
// Combinational evaluation of one touch event against the gesture state.
`default_nettype none

module tdt_eval (
  input  tdt_pkg::in_item_t  item_i,
  input  tdt_pkg::cfg_t      cfg_i,
  input  tdt_pkg::gesture_t  state_i,
  output tdt_pkg::out_item_t result_o,
  output tdt_pkg::gesture_t  state_o
);
  import tdt_pkg::*;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned SqW   = 2 * CoordW;

  logic single;
  logic is_down;
  logic is_up;

  logic signed [DiffW-1:0] dx_down, dy_down, dx_up, dy_up;
  logic [CoordW-1:0] ax_down, ay_down, ax_up, ay_up;
  logic [SqW:0] dsq_down, dsq_up;

  logic signed [StampW:0] dt_down, dt_up;
  logic in_time_down, in_time_up;
  logic dtap, tap;

  function automatic logic [CoordW-1:0] abs_diff(input logic signed [DiffW-1:0] d);
    logic signed [DiffW-1:0] n;
    begin
      n = d[DiffW-1] ? -d : d;
      abs_diff = n[CoordW-1:0];
    end
  endfunction

  always_comb begin
    single  = (item_i.pointer_count <= CountW'(1));
    is_down = single && (item_i.cmd == CMD_DOWN);
    is_up   = single && (item_i.cmd == CMD_UP);

    dx_down = DiffW'(item_i.pos_x) - DiffW'(state_i.last_tap_x);
    dy_down = DiffW'(item_i.pos_y) - DiffW'(state_i.last_tap_y);
    dx_up   = DiffW'(item_i.pos_x) - DiffW'(state_i.press_x);
    dy_up   = DiffW'(item_i.pos_y) - DiffW'(state_i.press_y);
    ax_down = abs_diff(dx_down);
    ay_down = abs_diff(dy_down);
    ax_up   = abs_diff(dx_up);
    ay_up   = abs_diff(dy_up);

    dsq_down = (SqW+1)'(ax_down * ax_down) + (SqW+1)'(ay_down * ay_down);
    dsq_up   = (SqW+1)'(ax_up * ax_up) + (SqW+1)'(ay_up * ay_up);

    // signed time differences: an earlier stamp counts as in time
    dt_down = $signed({1'b0, item_i.touch_stamp}) - $signed({1'b0, state_i.last_tap_stamp});
    dt_up   = $signed({1'b0, item_i.touch_stamp}) - $signed({1'b0, item_i.press_time});
    in_time_down = dt_down <= $signed({(StampW+1-TimeoutW)'(0), cfg_i.double_tap_timeout});
    in_time_up   = dt_up <= $signed({(StampW+1-TimeoutW)'(0), cfg_i.tap_timeout});

    dtap = is_down && in_time_down && (RadiusW'(dsq_down) < cfg_i.double_tap_radius_sq);
    tap  = is_up && in_time_up && (item_i.pointer_id == state_i.press_id) &&
           (RadiusW'(dsq_up) < cfg_i.tap_radius_sq);

    result_o.tap_seen        = tap;
    result_o.double_tap_seen = dtap;

    state_o = state_i;
    if (is_down) begin
      state_o.press_id = item_i.pointer_id;
      state_o.press_x  = item_i.pos_x;
      state_o.press_y  = item_i.pos_y;
    end
    if (tap) begin
      state_o.last_tap_stamp = item_i.touch_stamp;
      state_o.last_tap_x     = item_i.pos_x;
      state_o.last_tap_y     = item_i.pos_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tap_double_tap_detector_unit.sv
// Top level of the tap and double-tap detector: input register, evaluation, result register.
//
// Usage: touch events enter on the in channel (in_valid_i / in_stall_o / in_data_i) and
// produce exactly one result each on the out channel (out_valid_o / out_stall_i /
// out_data_o), in order. A transfer happens when valid is high and stall is low.
// From input transfer to result valid, an event first sits in the input register,
// then the evaluation (two squared-distance compares and two time compares)
// writes the result register and the gesture state at the same edge.
// Throughput is one event per cycle while the receiver does not stall; the state
// written by one event is seen by the next one.
// When the receiver stalls, the result register holds; the input register still takes
// one more event, after which in_stall_o rises until the result is taken.
// Reset (rst_ni low, asynchronous) empties both registers, clears the gesture state to
// zero and loads the default thresholds. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at the next edge and are meant for idle periods.
`default_nettype none

module tap_double_tap_detector_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  tdt_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output tdt_pkg::out_item_t              out_data_o,
  input  wire                             cfg_we_i,
  input  wire [tdt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [tdt_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tdt_pkg::*;

  cfg_t      cfg_q;
  gesture_t  state_q, state_d;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t res_q, res_d;
  logic      res_valid_q;
  logic      advance;

  assign advance     = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = item_valid_q && !advance;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_timeout          <= TapTimeoutRst;
      cfg_q.tap_radius_sq        <= TapRadiusSqRst;
      cfg_q.double_tap_timeout   <= DtapTimeoutRst;
      cfg_q.double_tap_radius_sq <= DtapRadiusSqRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_TIMEOUT:    cfg_q.tap_timeout          <= cfg_data_i[TimeoutW-1:0];
        CFG_TAP_RADIUS_SQ:  cfg_q.tap_radius_sq        <= cfg_data_i[RadiusW-1:0];
        CFG_DTAP_TIMEOUT:   cfg_q.double_tap_timeout   <= cfg_data_i[TimeoutW-1:0];
        CFG_DTAP_RADIUS_SQ: cfg_q.double_tap_radius_sq <= cfg_data_i[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  tdt_eval u_eval (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // result register and gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tdt_checker.sv
// Port-level checker for the tap and double-tap detector, bound to the top level.
`default_nettype none

module tdt_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input tdt_pkg::out_item_t  out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // tap comes only from an up, double tap only from a down
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.tap_seen && out_data_o.double_tap_seen))
    else $error("tap and double tap in one result");

  // input backpressure only when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

endmodule

bind tap_double_tap_detector_unit tdt_checker u_tdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
